### hdl/tgad_pkg.sv
`timescale 1ns / 1ps
package tgad_pkg;

  // Field widths of one result
  localparam int ADDR_W   = 34;
  localparam int STRIDE_W = 18;
  localparam int DIM_W    = 16;
  localparam int OUT_TDATA_W = 88;

  // Result queue depth; an item may push two results
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_SHORT_HEADER = 3'd1;
  localparam logic [2:0] ST_BAD_SIG      = 3'd2;
  localparam logic [2:0] ST_BAD_GEOMETRY = 3'd3;
  localparam logic [2:0] ST_SHORT_DATA   = 3'd4;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [7:0]        value;
    logic [2:0]        status;
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [7:0]        bits_per_pixel;
    logic              run_last;
  } result_t;

  // Pack the data fields of a result, address in the lowest bits
  function automatic logic [OUT_TDATA_W-1:0] pack_result(input result_t r);
    pack_result = {3'b000, r.bits_per_pixel, r.image_height, r.image_width,
                   r.status, r.value, r.address};
  endfunction

endpackage

### hdl/tga_stream_decoder_top.sv
`timescale 1ns / 1ps
// Streaming decoder for uncompressed TGA files (type 2 color, type 3 grey).
// Slave channel: one file byte per transaction in s_axis_tdata, s_axis_tlast
// on the final byte of the file. Master channel: results. m_axis_tuser is the
// kind (0 pixel byte write, 1 end-of-file status), m_axis_tlast marks the last
// result caused by one input byte. A status other than ok means every write
// of that file must be discarded.
// A result is valid on the master side once its byte has passed the input
// register and been pushed into the result queue.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver does not stall; a pixel byte that is also the end of the
// file gives two results, which leave one per cycle through the four-entry
// result queue. A byte is taken from the input register only while the queue
// has room for two results.
// Reset (rst, synchronous) empties the input register and the queue and
// returns the decoder to the start of a header. When the receiver stalls,
// results wait in the queue; bytes move on while it holds at most two
// results, then the input register holds one byte and s_axis_tready drops.
module tga_stream_decoder_top
  import tgad_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [7:0] byte_value
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [33:0] address, [41:34] value, [44:42] status, [60:45] image_width,
  // [76:61] image_height, [84:77] bits_per_pixel, [87:85] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser,  // [0] kind
  output logic                   m_axis_tlast
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              in_eof;
  logic              advance;
  result_t           res0;
  result_t           res1;
  logic [1:0]        res_count;
  logic [1:0]        push_count;
  result_t           head;
  logic              head_valid;
  logic [QCNT_W-1:0] q_count;

  // Move the held byte on while the queue has room for two results
  assign advance       = in_valid && (q_count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign s_axis_tready = !in_valid || advance;
  assign push_count    = advance ? res_count : 2'd0;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_eof  <= s_axis_tlast;
    end
  end

  tgad_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .byte_value  (in_byte),
    .end_of_file (in_eof),
    .res0        (res0),
    .res1        (res1),
    .res_count   (res_count)
  );

  tgad_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .pop        (m_axis_tready),
    .head       (head),
    .head_valid (head_valid),
    .count      (q_count)
  );

  // Drive the master channel from the queue head
  assign m_axis_tvalid = head_valid;
  assign m_axis_tdata  = pack_result(head);
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.run_last;

  // Queue never holds more results than it has entries
  assert property (@(posedge clk) disable iff (rst) q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // Two results from one byte only when that byte ends the file
  assert property (@(posedge clk) disable iff (rst) (advance && res_count == 2'd2) |-> in_eof)
    else $error("two results from a byte that does not end the file");

  // A status result always closes the results of its byte
  assert property (@(posedge clk) disable iff (rst)
                   (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("status result without tlast");

  // Every byte that ends the file pushes a status result last
  assert property (@(posedge clk) disable iff (rst)
                   (advance && in_eof) |-> (res_count != 2'd0))
    else $error("end of file gave no result");

endmodule

### hdl/tgad_parser.sv
`timescale 1ns / 1ps
module tgad_parser
  import tgad_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] byte_value,
  input  logic       end_of_file,
  output result_t    res0,
  output result_t    res1,
  output logic [1:0] res_count
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_PIXEL  = 2'd1;
  localparam logic [1:0] PH_IGNORE = 2'd2;

  localparam logic [4:0] IDX_SIG_END = 5'd12;
  localparam logic [4:0] IDX_TYPE    = 5'd2;
  localparam logic [4:0] IDX_W_LO    = 5'd12;
  localparam logic [4:0] IDX_W_HI    = 5'd13;
  localparam logic [4:0] IDX_H_LO    = 5'd14;
  localparam logic [4:0] IDX_H_HI    = 5'd15;
  localparam logic [4:0] IDX_DEPTH   = 5'd16;

  localparam logic [7:0] DEPTH_8  = 8'd8;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  logic [4:0]          header_index, header_index_next;
  logic [1:0]          phase, phase_next;
  logic                signature_bad, signature_bad_next;
  logic [DIM_W-1:0]    width_reg, width_reg_next;
  logic [DIM_W-1:0]    height_reg, height_reg_next;
  logic [DIM_W-1:0]    height_m1, height_m1_next;
  logic [7:0]          depth_reg, depth_reg_next;
  logic                origin_top, origin_top_next;
  logic [STRIDE_W-1:0] stride, stride_next;
  logic [DIM_W-1:0]    rows_left, rows_left_next;
  logic [STRIDE_W-1:0] column_byte, column_byte_next;
  logic [1:0]          pixel_byte, pixel_byte_next;
  logic [ADDR_W-1:0]   row_base, row_base_next;
  logic [2:0]          error_code, error_code_next;

  logic [ADDR_W-1:0]   last_row_base;
  logic [STRIDE_W-1:0] col_adj;
  logic [STRIDE_W-1:0] col_inc;
  logic [1:0]          pb_inc;
  logic                swap;
  logic                wrote;
  logic                geometry_bad;
  result_t             write_res;
  result_t             status_res;

  // Start of the bottom row, for images stored bottom-up (18 by 16 bit product)
  assign last_row_base = ADDR_W'(stride) * ADDR_W'(height_m1);

  assign geometry_bad = (width_reg == '0) || (height_reg == '0) ||
                        ((depth_reg != DEPTH_8) && (depth_reg != DEPTH_24) &&
                         (depth_reg != DEPTH_32));

  // Red/blue swap offset within the row
  assign swap = (depth_reg != DEPTH_8);
  always_comb begin
    col_adj = column_byte;
    if (swap && (pixel_byte == 2'd0)) begin
      col_adj = column_byte + STRIDE_W'(2);
    end else if (swap && (pixel_byte == 2'd2)) begin
      col_adj = column_byte - STRIDE_W'(2);
    end
  end

  assign col_inc = column_byte + STRIDE_W'(1);
  assign pb_inc  = pixel_byte + 2'd1;

  // Decode one byte and work out the next state
  always_comb begin
    header_index_next  = header_index;
    phase_next         = phase;
    signature_bad_next = signature_bad;
    width_reg_next     = width_reg;
    height_reg_next    = height_reg;
    height_m1_next     = height_m1;
    depth_reg_next     = depth_reg;
    origin_top_next    = origin_top;
    stride_next        = stride;
    rows_left_next     = rows_left;
    column_byte_next   = column_byte;
    pixel_byte_next    = pixel_byte;
    row_base_next      = row_base;
    error_code_next    = error_code;
    wrote              = 1'b0;

    write_res          = '0;
    write_res.kind     = KIND_WRITE;
    write_res.address  = row_base + ADDR_W'(col_adj);
    write_res.value    = byte_value;

    unique case (phase)
      PH_HEADER: begin
        header_index_next = header_index + 5'd1;
        if (header_index < IDX_SIG_END) begin
          if (header_index == IDX_TYPE) begin
            if ((byte_value != 8'd2) && (byte_value != 8'd3)) signature_bad_next = 1'b1;
          end else if (byte_value != 8'd0) begin
            signature_bad_next = 1'b1;
          end
        end else begin
          priority case (header_index)
            IDX_W_LO: width_reg_next[7:0]  = byte_value;
            IDX_W_HI: width_reg_next[15:8] = byte_value;
            IDX_H_LO: height_reg_next[7:0] = byte_value;
            IDX_H_HI: begin
              height_reg_next[15:8] = byte_value;
              height_m1_next = {byte_value, height_reg[7:0]} - DIM_W'(1);
            end
            IDX_DEPTH: begin
              depth_reg_next = byte_value;
              if (byte_value == DEPTH_8) begin
                stride_next = STRIDE_W'(width_reg);
              end else if (byte_value == DEPTH_24) begin
                stride_next = {1'b0, width_reg, 1'b0} + STRIDE_W'(width_reg);
              end else begin
                stride_next = {width_reg, 2'b00};
              end
            end
            default: begin
              // Descriptor byte: judge the header
              origin_top_next = byte_value[5];
              if (signature_bad) begin
                error_code_next = ST_BAD_SIG;
                phase_next      = PH_IGNORE;
              end else if (geometry_bad) begin
                error_code_next = ST_BAD_GEOMETRY;
                phase_next      = PH_IGNORE;
              end else begin
                rows_left_next   = height_reg;
                column_byte_next = '0;
                pixel_byte_next  = '0;
                row_base_next    = byte_value[5] ? '0 : last_row_base;
                phase_next       = PH_PIXEL;
              end
            end
          endcase
        end
      end
      PH_PIXEL: begin
        wrote = 1'b1;
        // Advance the byte position within the pixel
        if (depth_reg == DEPTH_8) begin
          pixel_byte_next = 2'd0;
        end else if ((depth_reg == DEPTH_24) && (pb_inc == 2'd3)) begin
          pixel_byte_next = 2'd0;
        end else begin
          pixel_byte_next = pb_inc;
        end
        // Advance the column, stepping rows at the end of each
        column_byte_next = col_inc;
        if (col_inc >= stride) begin
          column_byte_next = '0;
          rows_left_next   = rows_left - DIM_W'(1);
          if (origin_top) begin
            row_base_next = row_base + ADDR_W'(stride);
          end else if (row_base >= ADDR_W'(stride)) begin
            row_base_next = row_base - ADDR_W'(stride);
          end
          if (rows_left == DIM_W'(1)) begin
            error_code_next = ST_OK;
            phase_next      = PH_IGNORE;
          end
        end
      end
      default: begin
      end
    endcase

    status_res                = '0;
    status_res.kind           = KIND_STATUS;
    status_res.image_width    = width_reg_next;
    status_res.image_height   = height_reg_next;
    status_res.bits_per_pixel = depth_reg_next;
    status_res.run_last       = 1'b1;
    if (phase_next == PH_HEADER) begin
      status_res.status = ST_SHORT_HEADER;
    end else if (phase_next == PH_PIXEL) begin
      status_res.status = ST_SHORT_DATA;
    end else begin
      status_res.status = error_code_next;
    end

    // Return to the reset state after the status
    if (end_of_file) begin
      header_index_next  = '0;
      phase_next         = PH_HEADER;
      signature_bad_next = 1'b0;
      width_reg_next     = '0;
      height_reg_next    = '0;
      height_m1_next     = '0;
      depth_reg_next     = '0;
      origin_top_next    = 1'b0;
      stride_next        = '0;
      rows_left_next     = '0;
      column_byte_next   = '0;
      pixel_byte_next    = '0;
      row_base_next      = '0;
      error_code_next    = ST_OK;
    end
  end

  // Order the results of this byte
  always_comb begin
    res0 = write_res;
    res1 = status_res;
    res0.run_last = !end_of_file;
    res_count = 2'd0;
    if (wrote && end_of_file) begin
      res_count = 2'd2;
    end else if (wrote) begin
      res_count = 2'd1;
    end else if (end_of_file) begin
      res0      = status_res;
      res_count = 2'd1;
    end
  end

  // Update the decoder state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      header_index  <= '0;
      phase         <= PH_HEADER;
      signature_bad <= 1'b0;
      width_reg     <= '0;
      height_reg    <= '0;
      height_m1     <= '0;
      depth_reg     <= '0;
      origin_top    <= 1'b0;
      stride        <= '0;
      rows_left     <= '0;
      column_byte   <= '0;
      pixel_byte    <= '0;
      row_base      <= '0;
      error_code    <= ST_OK;
    end else if (advance) begin
      header_index  <= header_index_next;
      phase         <= phase_next;
      signature_bad <= signature_bad_next;
      width_reg     <= width_reg_next;
      height_reg    <= height_reg_next;
      height_m1     <= height_m1_next;
      depth_reg     <= depth_reg_next;
      origin_top    <= origin_top_next;
      stride        <= stride_next;
      rows_left     <= rows_left_next;
      column_byte   <= column_byte_next;
      pixel_byte    <= pixel_byte_next;
      row_base      <= row_base_next;
      error_code    <= error_code_next;
    end
  end

endmodule

### hdl/tgad_result_queue.sv
`timescale 1ns / 1ps
module tgad_result_queue
  import tgad_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  result_t           push0,
  input  result_t           push1,
  input  logic              pop,
  output result_t           head,
  output logic              head_valid,
  output logic [QCNT_W-1:0] count
);

  result_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr_p1;
  logic              pop_ok;

  assign wr_ptr_p1  = wr_ptr + QPTR_W'(1);
  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign pop_ok     = pop && head_valid;

  // Store up to two results per cycle
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entries[wr_ptr] <= push0;
    if (push_count == 2'd2) entries[wr_ptr_p1] <= push1;
  end

  // Advance the pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_count);
      rd_ptr <= rd_ptr + QPTR_W'(pop_ok);
      count  <= count + QCNT_W'(push_count) - QCNT_W'(pop_ok);
    end
  end

endmodule

### dv/tga_stream_decoder_top_test.sv
`timescale 1ns / 1ps
module tga_stream_decoder_top_test;
  import tgad_pkg::*;

  // Image type codes accepted in signature byte 2
  localparam logic [7:0] TGA_TYPE_COLOR = 8'd2;
  localparam logic [7:0] TGA_TYPE_GREY  = 8'd3;
  localparam int HEADER_BYTES = 18;
  localparam int RANDOM_ITEMS = 100;
  localparam int N_DIRECTED   = 16;

  typedef enum logic [1:0] {PH_HEADER, PH_PIXELS, PH_TRAILER} parse_phase_t;

  // One file to send: a signature byte may be corrupted, length counts all bytes
  typedef struct packed {
    int          bad_idx;
    logic [7:0]  bad_val;
    logic [7:0]  img_type;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  bpp;
    logic [7:0]  desc;
    int          length;
    logic [2:0]  status;
  } tga_file_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = 8'd0;   // [7:0] byte_value
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [33:0] address, [41:34] value, [44:42] status, [60:45] image_width,
  // [76:61] image_height, [84:77] bits_per_pixel, [87:85] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;          // [0] kind
  logic                   m_axis_tlast;

  bit      steady = 1'b0;
  int      mismatch_count = 0;
  int      items_sent = 0;
  result_t decoded_queue[$];

  // Decoder state mirror
  parse_phase_t parse_phase;
  logic [4:0]   hdr_count;
  logic         sig_bad;
  logic [15:0]  img_width;
  logic [15:0]  img_height;
  logic [7:0]   img_depth;
  logic         top_down;
  logic [34:0]  bytes_left;
  logic [17:0]  col_byte;
  logic [1:0]   pix_byte;
  logic [34:0]  row_addr;
  logic [2:0]   held_status;

  tga_stream_decoder_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Return the decoder mirror to the start of a file
  function automatic void clear_decoder();
    parse_phase = PH_HEADER;
    hdr_count   = '0;
    sig_bad     = 1'b0;
    img_width   = '0;
    img_height  = '0;
    img_depth   = '0;
    top_down    = 1'b0;
    bytes_left  = '0;
    col_byte    = '0;
    pix_byte    = '0;
    row_addr    = '0;
    held_status = ST_OK;
  endfunction

  // Advance the decoder mirror by one file byte and queue the results it causes
  function automatic void decode_byte(input logic [7:0] b, input logic eof);
    result_t     res;
    logic [4:0]  idx;
    logic [2:0]  px_bytes;
    logic [34:0] stride;
    logic [34:0] addr;
    logic [2:0]  st;
    int          made;
    made = 0;
    px_bytes = 3'(img_depth >> 3);
    stride = 35'(img_width) * 35'(px_bytes);
    case (parse_phase)
      PH_HEADER: begin
        idx = hdr_count;
        if (idx < 5'd12) begin
          if (idx == 5'd2) begin
            if (b != TGA_TYPE_COLOR && b != TGA_TYPE_GREY) sig_bad = 1'b1;
          end else if (b != 8'd0) begin
            sig_bad = 1'b1;
          end
        end else begin
          case (idx)
            5'd12:   img_width[7:0]   = b;
            5'd13:   img_width[15:8]  = b;
            5'd14:   img_height[7:0]  = b;
            5'd15:   img_height[15:8] = b;
            5'd16:   img_depth        = b;
            default: top_down         = b[5];
          endcase
        end
        hdr_count = idx + 5'd1;
        // Judge the header once its last byte is in
        if (idx >= 5'd17) begin
          if (sig_bad) begin
            held_status = ST_BAD_SIG;
            parse_phase = PH_TRAILER;
          end else if (img_width == 16'd0 || img_height == 16'd0 ||
                       (img_depth != 8'd8 && img_depth != 8'd24 && img_depth != 8'd32)) begin
            held_status = ST_BAD_GEOMETRY;
            parse_phase = PH_TRAILER;
          end else begin
            px_bytes   = 3'(img_depth >> 3);
            stride     = 35'(img_width) * 35'(px_bytes);
            bytes_left = stride * 35'(img_height);
            col_byte   = '0;
            pix_byte   = '0;
            row_addr   = top_down ? 35'd0 : 35'(img_height - 16'd1) * stride;
            parse_phase = PH_PIXELS;
          end
        end
      end
      PH_PIXELS: begin
        // Swap the first and third byte of a wide pixel
        addr = row_addr + 35'(col_byte);
        if (px_bytes >= 3'd3) begin
          if (pix_byte == 2'd0) addr = addr + 35'd2;
          else if (pix_byte == 2'd2) addr = addr - 35'd2;
        end
        res = '0;
        res.kind = KIND_WRITE;
        res.address = addr[ADDR_W-1:0];
        res.value = b;
        decoded_queue.push_back(res);
        made++;
        pix_byte = pix_byte + 2'd1;
        if ({1'b0, pix_byte} >= px_bytes) pix_byte = '0;
        // Step to the next row; a flipped image holds at its top row
        col_byte = col_byte + 18'd1;
        if (35'(col_byte) >= stride) begin
          col_byte = '0;
          if (top_down) row_addr = row_addr + stride;
          else if (row_addr >= stride) row_addr = row_addr - stride;
        end
        if (bytes_left != 35'd0) bytes_left = bytes_left - 35'd1;
        if (bytes_left == 35'd0) begin
          held_status = ST_OK;
          parse_phase = PH_TRAILER;
        end
      end
      default: ;
    endcase
    if (eof) begin
      if (parse_phase == PH_HEADER) st = ST_SHORT_HEADER;
      else if (parse_phase == PH_PIXELS) st = ST_SHORT_DATA;
      else st = held_status;
      res = '0;
      res.kind = KIND_STATUS;
      res.status = st;
      res.image_width = img_width;
      res.image_height = img_height;
      res.bits_per_pixel = img_depth;
      decoded_queue.push_back(res);
      made++;
      clear_decoder();
    end
    if (made > 0) begin
      res = decoded_queue.pop_back();
      res.run_last = 1'b1;
      decoded_queue.push_back(res);
    end
  endfunction

  // Byte idx of a file: signature, header fields, then random pixel data
  function automatic logic [7:0] file_byte(input tga_file_t f, input int idx);
    logic [7:0] b;
    if (idx < 12) b = (idx == 2) ? f.img_type : 8'd0;
    else if (idx == 12) b = f.w[7:0];
    else if (idx == 13) b = f.w[15:8];
    else if (idx == 14) b = f.h[7:0];
    else if (idx == 15) b = f.h[15:8];
    else if (idx == 16) b = f.bpp;
    else if (idx == 17) b = f.desc;
    else b = 8'($urandom_range(0, 255));
    if (idx == f.bad_idx) b = f.bad_val;
    return b;
  endfunction

  // Drive one byte, hold it until the transaction completes, then predict
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    decode_byte(b, last);
  endtask

  // Send a whole file; a typed status replaces the predicted one
  task automatic send_file(input tga_file_t f, input bit typed);
    result_t res;
    for (int i = 0; i < f.length; i++) begin
      send_byte(file_byte(f, i), i == f.length - 1);
    end
    if (typed) begin
      res = decoded_queue.pop_back();
      res.status = f.status;
      decoded_queue.push_back(res);
    end
  endtask

  // Mostly well-formed files, the rest broken in one way or another
  function automatic tga_file_t random_file();
    tga_file_t f;
    int pick;
    int npix;
    pick = $urandom_range(0, 99);
    f = '0;
    f.bad_idx  = -1;
    f.img_type = $urandom_range(0, 1) ? TGA_TYPE_COLOR : TGA_TYPE_GREY;
    f.w        = 16'($urandom_range(1, 4));
    f.h        = 16'($urandom_range(1, 3));
    case ($urandom_range(0, 2))
      0:       f.bpp = 8'd8;
      1:       f.bpp = 8'd24;
      default: f.bpp = 8'd32;
    endcase
    f.desc = 8'($urandom_range(0, 255));
    npix = int'(f.w) * int'(f.h) * int'(f.bpp >> 3);
    if (pick < 5) begin
      // Huge geometry, cut short
      f.w = 16'($urandom_range(1, 65535));
      f.h = 16'($urandom_range(1, 65535));
      f.length = HEADER_BYTES + $urandom_range(1, 40);
    end else if (pick < 70) begin
      f.length = HEADER_BYTES + npix;
      if ($urandom_range(0, 4) == 0) f.length += $urandom_range(1, 4);
      else if ($urandom_range(0, 5) == 0) f.length = HEADER_BYTES + $urandom_range(0, npix - 1);
    end else if (pick < 80) begin
      f.bad_idx = $urandom_range(0, 11);
      f.bad_val = 8'($urandom_range(0, 255));
      f.length  = HEADER_BYTES + $urandom_range(0, 6);
    end else if (pick < 90) begin
      case ($urandom_range(0, 2))
        0:       f.w = 16'd0;
        1:       f.h = 16'd0;
        default: f.bpp = 8'($urandom_range(0, 255));
      endcase
      f.length = HEADER_BYTES + $urandom_range(0, 6);
    end else begin
      if ($urandom_range(0, 1)) begin
        f.bad_idx = $urandom_range(0, 11);
        f.bad_val = 8'($urandom_range(0, 255));
      end
      f.length = $urandom_range(1, HEADER_BYTES - 1);
    end
    return f;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Receiver: stall at random except in the steady stretch
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : watch_results
    result_t seen;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.kind           = m_axis_tuser;
      seen.address        = m_axis_tdata[33:0];
      seen.value          = m_axis_tdata[41:34];
      seen.status         = m_axis_tdata[44:42];
      seen.image_width    = m_axis_tdata[60:45];
      seen.image_height   = m_axis_tdata[76:61];
      seen.bits_per_pixel = m_axis_tdata[84:77];
      seen.run_last       = m_axis_tlast;
      if (decoded_queue.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result: expected none actual kind %0d addr %0h value %0h",
                 $time, seen.kind, seen.address, seen.value);
      end else begin
        want = decoded_queue.pop_front();
        check_field("kind", 64'(want.kind), 64'(seen.kind));
        check_field("address", 64'(want.address), 64'(seen.address));
        check_field("value", 64'(want.value), 64'(seen.value));
        check_field("status", 64'(want.status), 64'(seen.status));
        check_field("image_width", 64'(want.image_width), 64'(seen.image_width));
        check_field("image_height", 64'(want.image_height), 64'(seen.image_height));
        check_field("bits_per_pixel", 64'(want.bits_per_pixel),
                    64'(seen.bits_per_pixel));
        check_field("run_last", 64'(want.run_last), 64'(seen.run_last));
      end
    end
  end

  // Directed files: bad_idx, bad_val, type, w, h, bpp, desc, length, status
  tga_file_t directed_files [N_DIRECTED] = '{
    // end of file on the very first byte
    '{-1, 8'h00, TGA_TYPE_COLOR, 16'd0, 16'd0, 8'd0, 8'h00, 1, ST_SHORT_HEADER},
    // one byte short of a full header, all fields at maximum
    '{-1, 8'h00, TGA_TYPE_COLOR, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 17, ST_SHORT_HEADER},
    // short header wins over a bad signature
    '{5, 8'hFF, TGA_TYPE_COLOR, 16'd1, 16'd1, 8'd8, 8'h00, 10, ST_SHORT_HEADER},
    '{0, 8'hFF, TGA_TYPE_COLOR, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 18, ST_BAD_SIG},
    // zero image type, trailing bytes ignored
    '{2, 8'h00, TGA_TYPE_GREY, 16'd2, 16'd2, 8'd8, 8'h00, 22, ST_BAD_SIG},
    '{11, 8'h01, TGA_TYPE_COLOR, 16'd1, 16'd1, 8'd8, 8'h00, 19, ST_BAD_SIG},
    '{-1, 8'h00, TGA_TYPE_COLOR, 16'd0, 16'd5, 8'd24, 8'h00, 18, ST_BAD_GEOMETRY},
    '{-1, 8'h00, TGA_TYPE_GREY, 16'd5, 16'd0, 8'd8, 8'h00, 21, ST_BAD_GEOMETRY},
    '{-1, 8'h00, TGA_TYPE_COLOR, 16'd2, 16'd2, 8'd16, 8'h00, 18, ST_BAD_GEOMETRY},
    // good header, file ends right after it
    '{-1, 8'h00, TGA_TYPE_COLOR, 16'd1, 16'd1, 8'd8, 8'h20, 18, ST_SHORT_DATA},
    // last pixel byte carries end of file: write plus status
    '{-1, 8'h00, TGA_TYPE_GREY, 16'd2, 16'd2, 8'd8, 8'h00, 22, ST_OK},
    '{-1, 8'h00, TGA_TYPE_COLOR, 16'd2, 16'd2, 8'd24, 8'hDF, 30, ST_OK},
    '{-1, 8'h00, TGA_TYPE_COLOR, 16'd1, 16'd3, 8'd32, 8'h20, 33, ST_OK},
    '{-1, 8'h00, TGA_TYPE_COLOR, 16'd3, 16'd2, 8'd24, 8'hFF, 28, ST_SHORT_DATA},
    // largest flipped geometry reaches the top of the address range
    '{-1, 8'h00, TGA_TYPE_COLOR, 16'hFFFF, 16'hFFFF, 8'd32, 8'h00, 23, ST_SHORT_DATA},
    '{-1, 8'h00, TGA_TYPE_GREY, 16'hFFFF, 16'hFFFF, 8'd8, 8'h20, 20, ST_SHORT_DATA}
  };

  initial begin
    int random_start;
    int drain_cycles;
    clear_decoder();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_DIRECTED; i++) send_file(directed_files[i], 1'b1);
    // Random files, with one stretch where neither side idles
    random_start = items_sent;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      steady = (items_sent >= random_start + 20) && (items_sent < random_start + 80);
      send_file(random_file(), 1'b0);
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;
    // Drain what is still owed, then let the pipeline settle
    drain_cycles = 0;
    while (decoded_queue.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (decoded_queue.size() != 0) begin
      mismatch_count++;
      $display("%0t missing results: expected %0d more actual 0", $time,
               decoded_queue.size());
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #2400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
hdl/tgad_pkg.sv
hdl/tgad_parser.sv
hdl/tgad_result_queue.sv
hdl/tga_stream_decoder_top.sv
dv/tga_stream_decoder_top_test.sv
